// ===== design/cfav_pkg.sv =====
// Package for the CRC-32 frame append and verify unit: shared types, constants
// and the byte fold function. No dependencies.
`default_nettype none

package cfav_pkg;

    localparam int CFAV_CRC_W     = 32;
    localparam int CFAV_BYTE_W    = 8;
    localparam int CFAV_CRC_BYTES = CFAV_CRC_W / CFAV_BYTE_W;
    localparam int CFAV_FIFO_DEPTH = 4;

    localparam logic [CFAV_CRC_W-1:0] CFAV_GENERATOR_RST = 32'h0982_3B6E;
    localparam logic [CFAV_CRC_W-1:0] CFAV_START_RST     = 32'hFFFF_FFFF;

    // Configuration register indexes.
    localparam logic [1:0] REG_GENERATOR   = 2'd0;
    localparam logic [1:0] REG_START_VALUE = 2'd1;
    localparam logic [1:0] REG_MODE        = 2'd2;

    // Mode register values.
    localparam logic MODE_GENERATE = 1'b0;
    localparam logic MODE_VERIFY   = 1'b1;

    // One classified byte, handed from the front to the back.
    typedef struct packed {
        logic [CFAV_BYTE_W-1:0] data_byte;
        logic                   frame_end;
        logic                   append;
        logic                   check_ok;
        logic [CFAV_CRC_W-1:0]  crc;
    } t_run;

    // Occupancy flags of the queue between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Folds one byte into the CRC, most significant bit first.
    function automatic logic [CFAV_CRC_W-1:0] cfav_fold(
        input logic [CFAV_CRC_W-1:0]  crc_in,
        input logic [CFAV_BYTE_W-1:0] data,
        input logic [CFAV_CRC_W-1:0]  poly
    );
        logic [CFAV_CRC_W-1:0] c;
        c = crc_in ^ {data, {(CFAV_CRC_W-CFAV_BYTE_W){1'b0}}};
        for (int i = 0; i < CFAV_BYTE_W; i++) begin
            if (c[CFAV_CRC_W-1]) begin
                c = (c << 1) ^ poly;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/crc32_frame_append_and_verify_unit.sv =====
// CRC-32 frame append and verify unit, top level. Instantiates the front,
// the queue and the back end. Depends on cfav_pkg.
// A byte's first result goes through the queue and the back end's output register.
// Throughput, unless stalled: one byte per cycle; a generate-mode frame end gives
// five results, one per cycle from the back end's single output register.
// Reset is synchronous and active low; it restores the register defaults.
`default_nettype none

module crc32_frame_append_and_verify_unit #(
    parameter int FIFO_DEPTH = cfav_pkg::CFAV_FIFO_DEPTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [cfav_pkg::CFAV_BYTE_W-1:0] i_data_byte,
    input  wire logic                            i_frame_end,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [cfav_pkg::CFAV_BYTE_W-1:0]     o_out_byte,
    output logic                                 o_is_crc_byte,
    output logic                                 o_run_last,
    output logic                                 o_frame_done,
    output logic                                 o_check_ok,
    output logic [cfav_pkg::CFAV_CRC_W-1:0]      o_crc_value,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [1:0]                      i_cfg_index,
    input  wire logic [cfav_pkg::CFAV_CRC_W-1:0] i_cfg_wdata
);
    import cfav_pkg::*;

    t_run       push_run;
    t_run       head_run;
    t_fifo_stat fifo_stat;
    logic       push;
    logic       pop;

    cfav_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_frame_end (i_frame_end),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fifo_stat (fifo_stat),
        .o_push      (push),
        .o_run       (push_run)
    );

    cfav_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_run),
        .i_pop   (pop),
        .o_data  (head_run),
        .o_stat  (fifo_stat)
    );

    cfav_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_run         (head_run),
        .i_fifo_stat   (fifo_stat),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_is_crc_byte (o_is_crc_byte),
        .o_run_last    (o_run_last),
        .o_frame_done  (o_frame_done),
        .o_check_ok    (o_check_ok),
        .o_crc_value   (o_crc_value)
    );

endmodule

`default_nettype wire

// ===== design/cfav_front.sv =====
// Front end: configuration registers, CRC state and the verify delay line.
// Classifies each accepted byte into a run entry. Depends on cfav_pkg.
`default_nettype none

module cfav_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [cfav_pkg::CFAV_BYTE_W-1:0]    i_data_byte,
    input  wire logic                                i_frame_end,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [1:0]                          i_cfg_index,
    input  wire logic [cfav_pkg::CFAV_CRC_W-1:0]     i_cfg_wdata,
    input  wire cfav_pkg::t_fifo_stat                i_fifo_stat,
    output logic                                     o_push,
    output cfav_pkg::t_run                           o_run
);
    import cfav_pkg::*;

    logic [CFAV_CRC_W-1:0]  r_generator;
    logic [CFAV_CRC_W-1:0]  r_start;
    logic                   r_mode;
    logic [CFAV_CRC_W-1:0]  r_crc;
    logic [CFAV_BYTE_W-1:0] r_trailer [CFAV_CRC_BYTES];
    logic [2:0]             r_bytes_seen;

    logic [CFAV_BYTE_W-1:0] fold_in;
    logic                   do_fold;
    logic [CFAV_CRC_W-1:0]  folded;
    logic [CFAV_CRC_W-1:0]  n_crc;
    logic [2:0]             n_bytes_seen;
    logic [CFAV_CRC_W-1:0]  stored;

    assign o_in_ready = !i_fifo_stat.full;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        // In verify mode the oldest held byte enters the CRC once four are held.
        fold_in      = (r_mode == MODE_VERIFY) ? r_trailer[0] : i_data_byte;
        do_fold      = (r_mode == MODE_GENERATE) || (r_bytes_seen >= 3'd4);
        folded       = cfav_fold(r_crc, fold_in, r_generator);
        n_crc        = do_fold ? folded : r_crc;
        n_bytes_seen = (r_bytes_seen < 3'd5) ? r_bytes_seen + 3'd1 : r_bytes_seen;
        stored       = {i_data_byte, r_trailer[3], r_trailer[2], r_trailer[1]};

        o_run.data_byte = i_data_byte;
        o_run.frame_end = i_frame_end;
        o_run.crc       = n_crc;
        o_run.append    = (r_mode == MODE_GENERATE) && i_frame_end;
        o_run.check_ok  = (r_mode == MODE_VERIFY) && i_frame_end
                          && (n_bytes_seen >= 3'd5) && (stored == n_crc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_generator  <= CFAV_GENERATOR_RST;
            r_start      <= CFAV_START_RST;
            r_mode       <= MODE_GENERATE;
            r_crc        <= CFAV_START_RST;
            r_bytes_seen <= 3'd0;
            for (int i = 0; i < CFAV_CRC_BYTES; i++) begin
                r_trailer[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_GENERATOR: begin
                        r_generator <= i_cfg_wdata;
                    end
                    REG_START_VALUE: begin
                        r_start <= i_cfg_wdata;
                        r_crc   <= i_cfg_wdata;
                    end
                    REG_MODE: begin
                        r_mode <= i_cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (o_push) begin
                if (i_frame_end) begin
                    r_crc        <= r_start;
                    r_bytes_seen <= 3'd0;
                    for (int i = 0; i < CFAV_CRC_BYTES; i++) begin
                        r_trailer[i] <= '0;
                    end
                end else begin
                    r_crc <= n_crc;
                    if (r_mode == MODE_VERIFY) begin
                        for (int i = 0; i < CFAV_CRC_BYTES - 1; i++) begin
                            r_trailer[i] <= r_trailer[i+1];
                        end
                        r_trailer[CFAV_CRC_BYTES-1] <= i_data_byte;
                        r_bytes_seen <= n_bytes_seen;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/cfav_fifo.sv =====
// Short queue of run entries between the front and the back end.
// Head entry is visible without a pop. Depends on cfav_pkg.
`default_nettype none

module cfav_fifo #(
    parameter int DEPTH = cfav_pkg::CFAV_FIFO_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cfav_pkg::t_run  i_data,
    input  wire logic            i_pop,
    output cfav_pkg::t_run       o_data,
    output cfav_pkg::t_fifo_stat o_stat
);
    import cfav_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_run          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/cfav_back.sv =====
// Back end: expands run entries into result transfers, appending the four
// CRC bytes after a generate-mode frame end. Depends on cfav_pkg.
`default_nettype none

module cfav_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire cfav_pkg::t_run                     i_run,
    input  wire cfav_pkg::t_fifo_stat               i_fifo_stat,
    output logic                                    o_pop,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [cfav_pkg::CFAV_BYTE_W-1:0]        o_out_byte,
    output logic                                    o_is_crc_byte,
    output logic                                    o_run_last,
    output logic                                    o_frame_done,
    output logic                                    o_check_ok,
    output logic [cfav_pkg::CFAV_CRC_W-1:0]         o_crc_value
);
    import cfav_pkg::*;

    localparam logic [1:0] LAST_PHASE = 2'(CFAV_CRC_BYTES - 1);

    logic                   r_out_valid;
    logic [CFAV_BYTE_W-1:0] r_out_byte;
    logic                   r_is_crc_byte;
    logic                   r_run_last;
    logic                   r_frame_done;
    logic                   r_check_ok;
    logic [CFAV_CRC_W-1:0]  r_crc_value;
    logic                   r_hold;
    logic [1:0]             r_phase;
    logic [CFAV_CRC_W-1:0]  r_crc;

    logic                   n_out_valid;
    logic [CFAV_BYTE_W-1:0] n_out_byte;
    logic                   n_is_crc_byte;
    logic                   n_run_last;
    logic                   n_frame_done;
    logic                   n_check_ok;
    logic [CFAV_CRC_W-1:0]  n_crc_value;
    logic                   n_hold;
    logic [1:0]             n_phase;
    logic [CFAV_CRC_W-1:0]  n_crc;
    logic                   load;
    logic [CFAV_CRC_W-1:0]  crc_shift;

    assign load      = !r_out_valid || i_out_ready;
    assign o_pop     = load && !r_hold && !i_fifo_stat.empty;
    assign crc_shift = r_crc >> {r_phase, 3'b000};

    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_byte    = r_out_byte;
        n_is_crc_byte = r_is_crc_byte;
        n_run_last    = r_run_last;
        n_frame_done  = r_frame_done;
        n_check_ok    = r_check_ok;
        n_crc_value   = r_crc_value;
        n_hold        = r_hold;
        n_phase       = r_phase;
        n_crc         = r_crc;
        if (load) begin
            if (r_hold) begin
                // Appended CRC bytes go out low byte first.
                n_out_valid   = 1'b1;
                n_out_byte    = crc_shift[CFAV_BYTE_W-1:0];
                n_is_crc_byte = 1'b1;
                n_run_last    = (r_phase == LAST_PHASE);
                n_frame_done  = 1'b1;
                n_check_ok    = 1'b0;
                n_crc_value   = r_crc;
                n_phase       = r_phase + 2'd1;
                n_hold        = (r_phase != LAST_PHASE);
            end else if (!i_fifo_stat.empty) begin
                n_out_valid   = 1'b1;
                n_out_byte    = i_run.data_byte;
                n_is_crc_byte = 1'b0;
                n_run_last    = !i_run.append;
                n_frame_done  = i_run.frame_end;
                n_check_ok    = i_run.check_ok;
                n_crc_value   = i_run.crc;
                n_hold        = i_run.append;
                n_phase       = 2'd0;
                n_crc         = i_run.crc;
            end else begin
                n_out_valid   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hold      <= 1'b0;
            r_phase     <= 2'd0;
        end else begin
            r_out_valid <= n_out_valid;
            r_hold      <= n_hold;
            r_phase     <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte    <= n_out_byte;
        r_is_crc_byte <= n_is_crc_byte;
        r_run_last    <= n_run_last;
        r_frame_done  <= n_frame_done;
        r_check_ok    <= n_check_ok;
        r_crc_value   <= n_crc_value;
        r_crc         <= n_crc;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_is_crc_byte = r_is_crc_byte;
    assign o_run_last    = r_run_last;
    assign o_frame_done  = r_frame_done;
    assign o_check_ok    = r_check_ok;
    assign o_crc_value   = r_crc_value;

endmodule

`default_nettype wire

// ===== design/cfav_checker.sv =====
// Port-level checker for the CRC-32 frame append and verify unit, bound to
// the top level. Depends on cfav_pkg.
`default_nettype none

module cfav_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [cfav_pkg::CFAV_BYTE_W-1:0] o_out_byte,
    input wire logic                             o_is_crc_byte,
    input wire logic                             o_run_last,
    input wire logic                             o_frame_done,
    input wire logic                             o_check_ok
);
    import cfav_pkg::*;

    // A result that is stalled keeps its byte.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Appended CRC bytes belong to a finished frame and never carry a check result.
    a_crc_byte_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_crc_byte |-> o_frame_done && !o_check_ok)
        else $error("CRC byte with wrong flags");

    a_check_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_check_ok |-> o_frame_done && o_run_last)
        else $error("check result outside a frame end");

    // The appended CRC bytes follow each other without a gap.
    a_crc_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_is_crc_byte && !o_run_last
        |=> o_out_valid && o_is_crc_byte)
        else $error("gap inside the appended CRC bytes");

endmodule

bind crc32_frame_append_and_verify_unit cfav_checker u_cfav_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_byte    (o_out_byte),
    .o_is_crc_byte (o_is_crc_byte),
    .o_run_last    (o_run_last),
    .o_frame_done  (o_frame_done),
    .o_check_ok    (o_check_ok)
);

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for crc32_frame_append_and_verify_unit: CRC append and check on byte frames,
// with random stalls on both channels, checked against a built-in CRC predictor.
// Depends on cfav_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int RANDOM_BYTES    = 130;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 120;

    // Index 3 is not a register; writes to it must have no effect.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_crc_byte;
        logic        run_last;
        logic        frame_done;
        logic        check_ok;
        logic [31:0] crc_value;
    } crc_result_t;

    class crc_frame_checker;
        logic [31:0] generator;
        logic [31:0] start_value;
        logic        mode;
        logic [31:0] crc_reg;
        logic [7:0]  trailer[4];
        int          bytes_seen;
        crc_result_t expected_out_bytes[$];
        int          mismatches;

        function new();
            generator   = cfav_pkg::CFAV_GENERATOR_RST;
            start_value = cfav_pkg::CFAV_START_RST;
            mode        = cfav_pkg::MODE_GENERATE;
            mismatches  = 0;
            close_frame();
        endfunction

        function void close_frame();
            crc_reg = start_value;
            for (int k = 0; k < 4; k++) trailer[k] = 8'h00;
            bytes_seen = 0;
        endfunction

        function logic [31:0] fold(logic [31:0] crc, logic [7:0] b);
            logic [31:0] c;
            c = crc ^ {b, 24'h0};
            for (int i = 0; i < 8; i++) begin
                c = c[31] ? ((c << 1) ^ generator) : (c << 1);
            end
            return c;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                cfav_pkg::REG_GENERATOR: generator = val;
                cfav_pkg::REG_START_VALUE: begin
                    start_value = val;
                    crc_reg     = val;
                end
                cfav_pkg::REG_MODE: mode = val[0];
                default: ;
            endcase
        endfunction

        // Works out every output transfer that one accepted byte causes.
        function void accept_byte(logic [7:0] b, logic fe);
            crc_result_t r;
            logic [31:0] stored;
            r.is_crc_byte = 1'b0;
            r.out_byte    = b;
            r.frame_done  = fe;
            if (mode == cfav_pkg::MODE_GENERATE) begin
                crc_reg     = fold(crc_reg, b);
                r.run_last  = !fe;
                r.check_ok  = 1'b0;
                r.crc_value = crc_reg;
                expected_out_bytes.push_back(r);
                if (fe) begin
                    for (int k = 0; k < 4; k++) begin
                        r.out_byte    = crc_reg[8*k +: 8];
                        r.is_crc_byte = 1'b1;
                        r.run_last    = (k == 3);
                        expected_out_bytes.push_back(r);
                    end
                    close_frame();
                end
            end else begin
                // The oldest held byte enters the CRC once four bytes are held.
                if (bytes_seen >= 4) crc_reg = fold(crc_reg, trailer[0]);
                trailer[0] = trailer[1];
                trailer[1] = trailer[2];
                trailer[2] = trailer[3];
                trailer[3] = b;
                if (bytes_seen < 5) bytes_seen++;
                stored      = {trailer[3], trailer[2], trailer[1], trailer[0]};
                r.run_last  = 1'b1;
                r.check_ok  = fe && bytes_seen >= 5 && stored == crc_reg;
                r.crc_value = crc_reg;
                expected_out_bytes.push_back(r);
                if (fe) close_frame();
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_out_byte(crc_result_t got);
            crc_result_t want;
            if (expected_out_bytes.size() == 0) begin
                $error("out_byte: expected no transfer, actual 0x%0h", got.out_byte);
                mismatches++;
                return;
            end
            want = expected_out_bytes.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("is_crc_byte", want.is_crc_byte, got.is_crc_byte);
            compare_field("run_last", want.run_last, got.run_last);
            compare_field("frame_done", want.frame_done, got.frame_done);
            compare_field("check_ok", want.check_ok, got.check_ok);
            compare_field("crc_value", want.crc_value, got.crc_value);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_frame_end;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_byte;
    logic        o_is_crc_byte;
    logic        o_run_last;
    logic        o_frame_done;
    logic        o_check_ok;
    logic [31:0] o_crc_value;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_wdata;

    crc_frame_checker sb = new();
    logic [7:0]       frame_buf[$];
    bit               steady_run = 1'b0;
    bit               hold_off_request = 1'b0;
    int unsigned      cycle_count = 0;

    crc32_frame_append_and_verify_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_frame_end  (i_frame_end),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_is_crc_byte(o_is_crc_byte),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done),
        .o_check_ok   (o_check_ok),
        .o_crc_value  (o_crc_value),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        crc_result_t seen;
        seen.out_byte    = o_out_byte;
        seen.is_crc_byte = o_is_crc_byte;
        seen.run_last    = o_run_last;
        seen.frame_done  = o_frame_done;
        seen.check_ok    = o_check_ok;
        seen.crc_value   = o_crc_value;
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_out_byte(seen);
    end

    // Output ready: random high and low runs, plus one long hold-off on request.
    initial begin : out_ready_driver
        int hold;
        int hold_off;
        int pick;
        hold     = 0;
        hold_off = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_off         = HOLD_OFF_CYCLES;
            end
            if (hold_off > 0) begin
                hold_off--;
                i_out_ready <= 1'b0;
            end else if (hold > 0) begin
                hold--;
            end else if (!i_out_ready) begin
                i_out_ready <= 1'b1;
                hold = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(0, 20);
            end else begin
                i_out_ready <= 1'b0;
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    hold = $urandom_range(0, 2);
                end else if (pick < 95) begin
                    hold = $urandom_range(3, 9);
                end else begin
                    hold = $urandom_range(20, 40);
                end
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady_run || pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom());
    endfunction

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fe);
        int gap;
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_frame_end <= fe;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.accept_byte(b, fe);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input bit close);
        foreach (frame_buf[i]) send_byte(frame_buf[i], close && i == frame_buf.size() - 1);
    endtask

    // Stops the input and waits until every expected transfer has come out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_out_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic build_random_frame(input int len);
        frame_buf.delete();
        repeat (len) frame_buf.push_back(rand_byte());
    endtask

    // Payload plus its CRC as a little-endian trailer, computed from the
    // predictor's current CRC so that a frame started here checks out unless corrupted.
    task automatic build_verify_frame(input int payload_len, input bit corrupt);
        logic [31:0] crc;
        int          pos;
        build_random_frame(payload_len);
        crc = sb.crc_reg;
        foreach (frame_buf[i]) crc = sb.fold(crc, frame_buf[i]);
        for (int k = 0; k < 4; k++) frame_buf.push_back(crc[8*k +: 8]);
        if (corrupt) begin
            pos = $urandom_range(0, frame_buf.size() - 1);
            frame_buf[pos] = frame_buf[pos] ^ 8'(1 << $urandom_range(0, 7));
        end
    endtask

    initial begin : stimulus
        int          phase;
        int          random_bytes;
        int          n_frames;
        int          pick;
        logic [31:0] gen_val;
        logic [31:0] start_val;
        logic        mode_val;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= 8'h00;
        i_frame_end <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= cfav_pkg::REG_GENERATOR;
        i_cfg_wdata <= 32'h0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Generate mode on reset registers: a one-byte frame and extreme bytes.
        frame_buf = '{8'h00};
        send_frame(1'b1);
        frame_buf = '{8'hFF, 8'h00, 8'h80};
        send_frame(1'b1);

        // A new start value in the middle of a frame restarts its CRC.
        frame_buf = '{8'h12, 8'h34};
        send_frame(1'b0);
        drain_results();
        write_cfg(cfav_pkg::REG_START_VALUE, 32'h0);
        write_cfg(REG_UNUSED, 32'hFFFF_FFFF);
        frame_buf = '{8'h56};
        send_frame(1'b1);

        // Switch to verify in the middle of a frame, then good, short and bad frames.
        frame_buf = '{8'h9C};
        send_frame(1'b0);
        drain_results();
        write_cfg(cfav_pkg::REG_MODE, {31'h0, cfav_pkg::MODE_VERIFY});
        build_verify_frame(1, 1'b0);
        send_frame(1'b1);
        frame_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame(1'b1);
        frame_buf = '{8'h00};
        send_frame(1'b1);
        build_verify_frame(2, 1'b1);
        send_frame(1'b1);

        phase        = 0;
        random_bytes = 0;
        // The long output hold-off comes in the third phase, so at least three run.
        while (random_bytes < RANDOM_BYTES || phase < 3) begin
            drain_results();
            case (phase % 6)
                0: gen_val = cfav_pkg::CFAV_GENERATOR_RST;
                1: gen_val = 32'h04C1_1DB7;
                2: gen_val = 32'h0000_0000;
                3: gen_val = 32'hFFFF_FFFF;
                default: gen_val = $urandom();
            endcase
            case (phase % 3)
                0: start_val = 32'hFFFF_FFFF;
                1: start_val = 32'h0000_0000;
                default: start_val = $urandom();
            endcase
            mode_val = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
            write_cfg(cfav_pkg::REG_GENERATOR, gen_val);
            // Sometimes the start value is left alone so an open frame carries over.
            if (phase < 3 || $urandom_range(0, 9) < 7) begin
                write_cfg(cfav_pkg::REG_START_VALUE, start_val);
            end
            write_cfg(cfav_pkg::REG_MODE, ($urandom() & 32'hFFFF_FFFE) | mode_val);
            if (phase == 1) write_cfg(REG_UNUSED, $urandom());
            if (phase == 2) hold_off_request = 1'b1;

            n_frames = $urandom_range(3, 6);
            for (int f = 0; f < n_frames; f++) begin
                steady_run = ($urandom_range(0, 3) == 0);
                if (sb.mode == cfav_pkg::MODE_VERIFY) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 14) begin
                        build_verify_frame($urandom_range(1, 8), 1'b0);
                    end else if (pick < 17) begin
                        build_verify_frame($urandom_range(1, 8), 1'b1);
                    end else if (pick < 19) begin
                        build_random_frame($urandom_range(1, 4));
                    end else begin
                        build_random_frame($urandom_range(5, 9));
                    end
                end else begin
                    build_random_frame($urandom_range(1, 8));
                end
                send_frame(f < n_frames - 1 || $urandom_range(0, 3) != 0);
                random_bytes += frame_buf.size();
            end
            steady_run = 1'b0;
            phase++;
        end

        drain_results();
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== crc32_frame_append_and_verify_unit.f =====
design/cfav_pkg.sv
design/cfav_front.sv
design/cfav_fifo.sv
design/cfav_back.sv
design/crc32_frame_append_and_verify_unit.sv
design/cfav_checker.sv
verif/tb.sv
